// File: rtl/gb5_pkg.sv
package gb5_pkg;

  // field and register widths
  localparam int PIX_W    = 8;
  localparam int COL_W    = 9;
  localparam int ROW_W    = 12;
  localparam int CFG_W    = 12;
  localparam int LAG_W    = COL_W + 2;

  // line store word: four stored rows of one column, oldest row in the low byte
  localparam int STORE_ROWS = 4;
  localparam int WORD_W     = STORE_ROWS * PIX_W;

  // window and arithmetic
  localparam int WIN_N       = 5;
  localparam int ROWSUM_W    = 14;
  localparam int TOTAL_W     = 16;
  localparam int SCALE_W     = 24;
  localparam int NORM_FACTOR = 206;
  localparam int NORM_SHIFT  = 15;
  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [3:0] GAUSS_MASK [WIN_N][WIN_N] = '{
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd5, 4'd12, 4'd15, 4'd12, 4'd5},
    '{4'd4, 4'd9,  4'd12, 4'd9,  4'd4},
    '{4'd2, 4'd4,  4'd5,  4'd4,  4'd2}
  };

  // register reset values
  localparam logic [COL_W-1:0] WIDTH_RESET  = 9'd256;
  localparam logic [ROW_W-1:0] HEIGHT_RESET = 12'd256;

  // stored row that holds the center row of the window after an update
  localparam logic [1:0] SLOT_CENTER = 2'd1;

  // result queue
  localparam int FIFO_DEPTH = 8;

  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_in;
    logic             is_padding;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             frame_end;
  } out_item_t;

  // per-item decisions made at accept time
  typedef struct packed {
    logic       is_pixel;
    logic       emit;
    logic       inner;
    logic       frame_end;
    logic       own_b;
    logic [1:0] slot;
  } ctrl_t;

  // result info carried alongside the blur pipeline
  typedef struct packed {
    logic             inner;
    logic             frame_end;
    logic [PIX_W-1:0] border;
  } pipe_t;

endpackage

// File: rtl/gb5_ctrl.sv
module gb5_ctrl import gb5_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int AW        = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             accept,
  input  in_item_t         in_data,
  output logic             issue,
  output logic             reserve,
  output ctrl_t            ctrl,
  output logic [AW-1:0]    addr_a,
  output logic [AW-1:0]    addr_b
);

  logic [COL_W-1:0] width_r;
  logic [ROW_W-1:0] height_r;
  logic [COL_W-1:0] in_col_r, out_col_r;
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [LAG_W-1:0] diff_r;

  logic [COL_W-1:0] w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [LAG_W-1:0] lag;
  logic             is_pix, done, restart;
  logic [COL_W-1:0] ic, oc;
  logic [ROW_W-1:0] ir, orw;
  logic [LAG_W-1:0] df;
  logic             emit;
  logic [ROW_W:0]   orw_p2;
  logic [COL_W:0]   oc_p2;
  logic [COL_W-1:0] in_col_nxt, out_col_nxt;
  logic [ROW_W-1:0] in_row_nxt, out_row_nxt;
  logic [LAG_W-1:0] diff_nxt;

  // effective frame size
  always_comb begin
    if (width_r == '0) begin
      w_eff = COL_W'(1);
    end else if (int'(width_r) > MAX_WIDTH) begin
      w_eff = COL_W'(MAX_WIDTH);
    end else begin
      w_eff = width_r;
    end
  end

  assign h_eff = (height_r == '0) ? ROW_W'(1) : height_r;
  assign lag   = LAG_W'({w_eff, 1'b0}) + LAG_W'(2);

  // a pixel after a complete frame starts the next one
  assign is_pix  = !in_data.is_padding;
  assign done    = in_row_r >= h_eff;
  assign restart = is_pix && done;

  assign ic  = restart ? '0 : in_col_r;
  assign ir  = restart ? '0 : in_row_r;
  assign oc  = restart ? '0 : out_col_r;
  assign orw = restart ? '0 : out_row_r;
  assign df  = restart ? '0 : diff_r;

  // result due: two rows and two columns behind on pixels, flush on padding
  assign emit = is_pix ? ((df >= lag) && (orw < h_eff)) : (done && (orw < h_eff));

  assign orw_p2 = {1'b0, orw} + (ROW_W+1)'(2);
  assign oc_p2  = {1'b0, oc} + (COL_W+1)'(2);

  always_comb begin
    ctrl.is_pixel  = is_pix;
    ctrl.emit      = emit;
    ctrl.inner     = is_pix && (orw >= ROW_W'(2)) && (orw_p2 < {1'b0, h_eff})
                     && (oc >= COL_W'(2)) && (oc_p2 < {1'b0, w_eff});
    ctrl.frame_end = (orw == h_eff - ROW_W'(1)) && (oc == w_eff - COL_W'(1));
    ctrl.own_b     = is_pix && (ic == oc);
    ctrl.slot      = is_pix ? SLOT_CENTER : (orw[1:0] - h_eff[1:0]);
  end

  assign issue   = accept && (is_pix || emit);
  assign reserve = accept && emit;
  assign addr_a  = AW'(ic);
  assign addr_b  = AW'(oc);

  // counter advance
  always_comb begin
    in_col_nxt  = ic;
    in_row_nxt  = ir;
    out_col_nxt = oc;
    out_row_nxt = orw;
    if (is_pix) begin
      if (ic + COL_W'(1) == w_eff) begin
        in_col_nxt = '0;
        in_row_nxt = ir + ROW_W'(1);
      end else begin
        in_col_nxt = ic + COL_W'(1);
      end
    end
    if (emit) begin
      if (oc + COL_W'(1) == w_eff) begin
        out_col_nxt = '0;
        out_row_nxt = orw + ROW_W'(1);
      end else begin
        out_col_nxt = oc + COL_W'(1);
      end
    end
    diff_nxt = df + LAG_W'(is_pix) - LAG_W'(emit);
  end

  // registers and position counters; any register write restarts the frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r   <= WIDTH_RESET;
      height_r  <= HEIGHT_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      diff_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  width_r  <= cfg_wdata[COL_W-1:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_wdata[ROW_W-1:0];
      endcase
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      diff_r    <= '0;
    end else if (accept) begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      diff_r    <= diff_nxt;
    end
  end

  // output position never runs ahead of the input position, nor more than one lag behind it
  a_diff_bound: assert property (@(posedge clk) disable iff (!rst_n)
    diff_r <= lag)
    else $error("result position more than one lag behind input");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r <= in_row_r)
    else $error("output row ahead of input row");

endmodule

// File: rtl/gb5_line_store.sv
module gb5_line_store import gb5_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  parameter int AW        = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              issue,
  input  logic [AW-1:0]     addr_a,
  input  logic [AW-1:0]     addr_b,
  input  logic              wr_en,
  input  logic [WORD_W-1:0] wr_data,
  output logic [WORD_W-1:0] word_a,
  output logic [WORD_W-1:0] word_b
);

  logic [WORD_W-1:0] mem [MAX_WIDTH];
  logic [WORD_W-1:0] rd_a_r, rd_b_r, byp_word_r;
  logic [AW-1:0]     addr_a_r;
  logic              byp_a_r, byp_b_r;

  // one write at the column just read, two registered reads
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_a_r] <= wr_data;
    end
    if (issue) begin
      rd_a_r     <= mem[addr_a];
      rd_b_r     <= mem[addr_b];
      byp_word_r <= wr_data;
      addr_a_r   <= addr_a;
    end
  end

  // a write landing on the same edge as a read is forwarded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_a_r <= 1'b0;
      byp_b_r <= 1'b0;
    end else if (issue) begin
      byp_a_r <= wr_en && (addr_a_r == addr_a);
      byp_b_r <= wr_en && (addr_a_r == addr_b);
    end
  end

  assign word_a = byp_a_r ? byp_word_r : rd_a_r;
  assign word_b = byp_b_r ? byp_word_r : rd_b_r;

endmodule

// File: rtl/gb5_conv.sv
module gb5_conv import gb5_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       shift_en,
  input  logic [WIN_N-1:0][PIX_W-1:0] col_in,
  output logic [PIX_W-1:0]           blur_val
);

  logic [PIX_W-1:0]    win_r [WIN_N][WIN_N];
  logic [ROWSUM_W-1:0] rowsum_nxt [WIN_N];
  logic [ROWSUM_W-1:0] rowsum_r [WIN_N];
  logic [TOTAL_W-1:0]  total_nxt, total_r;
  logic [SCALE_W-1:0]  scaled;
  logic [PIX_W:0]      shifted;

  // 5x5 window, column 4 newest
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < WIN_N; r++) begin
        for (int j = 0; j < WIN_N; j++) begin
          win_r[r][j] <= '0;
        end
      end
    end else if (shift_en) begin
      for (int r = 0; r < WIN_N; r++) begin
        for (int j = 0; j < WIN_N - 1; j++) begin
          win_r[r][j] <= win_r[r][j+1];
        end
        win_r[r][WIN_N-1] <= col_in[r];
      end
    end
  end

  // weighted row sums
  always_comb begin
    for (int r = 0; r < WIN_N; r++) begin
      rowsum_nxt[r] = '0;
      for (int j = 0; j < WIN_N; j++) begin
        rowsum_nxt[r] = rowsum_nxt[r]
                        + ROWSUM_W'(win_r[r][j]) * ROWSUM_W'(GAUSS_MASK[r][j]);
      end
    end
  end

  always_comb begin
    total_nxt = '0;
    for (int r = 0; r < WIN_N; r++) begin
      total_nxt = total_nxt + TOTAL_W'(rowsum_r[r]);
    end
  end

  always_ff @(posedge clk) begin
    rowsum_r <= rowsum_nxt;
    total_r  <= total_nxt;
  end

  // normalize by 1/159 in fixed point, then clip
  assign scaled   = SCALE_W'(total_r) * SCALE_W'(NORM_FACTOR);
  assign shifted  = (PIX_W+1)'(scaled >> NORM_SHIFT);
  assign blur_val = shifted[PIX_W] ? PIX_MAX : shifted[PIX_W-1:0];

endmodule

// File: rtl/gb5_out_fifo.sv
module gb5_out_fifo import gb5_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      reserve,
  input  logic      push,
  input  out_item_t push_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  output logic      full
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  out_item_t        mem [FIFO_DEPTH];
  logic [CNT_W-1:0] wr_ptr_r, rd_ptr_r, pending_r, occ;
  logic             pop;

  assign occ       = wr_ptr_r - rd_ptr_r;
  assign out_valid = occ != '0;
  assign out_data  = mem[rd_ptr_r[PTR_W-1:0]];
  assign pop       = out_valid && !out_stall;

  // credit: results in flight plus results queued
  assign full = pending_r >= CNT_W'(FIFO_DEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r[PTR_W-1:0]] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      pending_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + CNT_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + CNT_W'(1);
      end
      pending_r <= pending_r + CNT_W'(reserve) - CNT_W'(pop);
    end
  end

  // every queued or arriving result was reserved at accept time
  a_push_reserved: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (occ < pending_r))
    else $error("result pushed without a reservation");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ <= pending_r)
    else $error("queue holds more results than reserved");

endmodule

// File: rtl/gaussian_blur_5x5.sv
// Channel  Ports                               Transfer
// input    in_valid, in_stall, in_data         valid && !stall at clk rise
// result   out_valid, out_stall, out_data      valid && !stall at clk rise
// config   cfg_we, cfg_index, cfg_wdata        cfg_we at clk rise
//
// One item per cycle while in_stall is low; each result passes through the line
// store read, two adder stages and the scale.
// Reset is synchronous; the line store is not cleared, stale columns never
// reach a result. An 8-entry result queue with credits decouples the sides;
// in_stall rises only when eight results are in flight or queued.
module gaussian_blur_5x5 import gb5_pkg::*; #(
  parameter int MAX_WIDTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic              accept, issue, reserve, full;
  ctrl_t             ctrl_s0, s1_ctrl_r;
  logic [AW-1:0]     addr_a, addr_b;
  logic              s1_valid_r;
  logic [PIX_W-1:0]  s1_pix_r;
  logic [WORD_W-1:0] word_a, word_b, wr_data, border_word;
  logic              wr_en;
  logic [PIX_W-1:0]  blur_val;
  pipe_t             s2_r, s3_r, s4_r;
  logic              s2_valid_r, s3_valid_r, s4_valid_r;
  out_item_t         push_data;

  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  gb5_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .accept    (accept),
    .in_data   (in_data),
    .issue     (issue),
    .reserve   (reserve),
    .ctrl      (ctrl_s0),
    .addr_a    (addr_a),
    .addr_b    (addr_b)
  );

  // stage 1: line store data arrives
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_ctrl_r <= ctrl_s0;
      s1_pix_r  <= in_data.pixel_in;
    end
  end

  // stored rows move up one, newest pixel goes on top
  assign wr_en   = s1_valid_r && s1_ctrl_r.is_pixel;
  assign wr_data = {s1_pix_r, word_a[WORD_W-1:PIX_W]};

  gb5_line_store #(
    .MAX_WIDTH (MAX_WIDTH),
    .AW        (AW)
  ) u_line_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .issue   (issue),
    .addr_a  (addr_a),
    .addr_b  (addr_b),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .word_a  (word_a),
    .word_b  (word_b)
  );

  // border copy comes from the column being written when they coincide
  assign border_word = s1_ctrl_r.own_b ? wr_data : word_b;

  gb5_conv u_conv (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (wr_en),
    .col_in   ({s1_pix_r, word_a}),
    .blur_val (blur_val)
  );

  // stages 2 to 4 follow the blur arithmetic
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r && s1_ctrl_r.emit;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_r.inner     <= s1_ctrl_r.inner;
    s2_r.frame_end <= s1_ctrl_r.frame_end;
    s2_r.border    <= border_word[s1_ctrl_r.slot*PIX_W +: PIX_W];
    s3_r           <= s2_r;
    s4_r           <= s3_r;
  end

  always_comb begin
    push_data.pixel_out = s4_r.inner ? blur_val : s4_r.border;
    push_data.frame_end = s4_r.frame_end;
  end

  gb5_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .reserve   (reserve),
    .push      (s4_valid_r),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .full      (full)
  );

endmodule

// File: test/gaussian_blur_5x5_check.sv
module gaussian_blur_5x5_check import gb5_pkg::*; #(
  parameter int LINE_MAX = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  logic             out_stall,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [0:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               error_count,
  output int               pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // normalization: 206 / 2^15 is just under 1/159
  localparam int SCALE_MUL   = 206;
  localparam int SCALE_SHIFT = 15;
  localparam int PIX_CEIL    = 255;
  localparam int SIZE_RESET  = 256;

  // predictor state
  logic [COL_W-1:0] width_reg;
  logic [ROW_W-1:0] height_reg;
  logic [PIX_W-1:0] line_rows [4][LINE_MAX];
  logic [PIX_W-1:0] win [5][5];
  int               in_col, in_row, out_col, out_row;
  out_item_t        expected_pixels [$];

  task automatic report_error(input string msg);
    $display("[%0t] ERROR %s", $time, msg);
    error_count++;
  endtask

  // Gaussian taps depend only on the distance from the center tap
  function automatic int mask_weight(input int r, input int c);
    int dr, dc;
    dr = (r > 2) ? r - 2 : 2 - r;
    dc = (c > 2) ? c - 2 : 2 - c;
    case (dr * 3 + dc)
      0:       return 15;
      1, 3:    return 12;
      2, 6:    return 5;
      4:       return 9;
      5, 7:    return 4;
      default: return 2;
    endcase
  endfunction

  function automatic int active_width();
    if (width_reg == 0) return 1;
    if (int'(width_reg) > LINE_MAX) return LINE_MAX;
    return int'(width_reg);
  endfunction

  function automatic int active_height();
    return (height_reg == 0) ? 1 : int'(height_reg);
  endfunction

  task automatic restart_frame();
    in_col  = 0;
    in_row  = 0;
    out_col = 0;
    out_row = 0;
  endtask

  task automatic reset_model();
    width_reg   = COL_W'(SIZE_RESET);
    height_reg  = ROW_W'(SIZE_RESET);
    error_count = 0;
    for (int k = 0; k < 4; k++)
      for (int c = 0; c < LINE_MAX; c++) line_rows[k][c] = '0;
    for (int r = 0; r < 5; r++)
      for (int c = 0; c < 5; c++) win[r][c] = '0;
    expected_pixels.delete();
    restart_frame();
  endtask

  // queue the pixel at (out_row, out_col); slot picks the stored row for border copies
  task automatic push_result(input int slot, input bit window_ok, input int w, input int h);
    int        r, c, sum;
    bit        inner;
    out_item_t res;
    r = out_row;
    c = out_col;
    inner = window_ok && r >= 2 && r + 2 < h && c >= 2 && c + 2 < w;
    if (inner) begin
      sum = 0;
      for (int i = 0; i < 5; i++)
        for (int j = 0; j < 5; j++) sum += int'(win[i][j]) * mask_weight(i, j);
      sum = (sum * SCALE_MUL) >> SCALE_SHIFT;
      if (sum > PIX_CEIL) sum = PIX_CEIL;
      res.pixel_out = sum[PIX_W-1:0];
    end else begin
      res.pixel_out = line_rows[slot & 3][c % LINE_MAX];
    end
    res.frame_end = (r == h - 1) && (c == w - 1);
    expected_pixels.push_back(res);
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
  endtask

  // one accepted input transaction
  task automatic blur_step(input in_item_t it);
    int w, h, total, lag, pin, pout, col;
    w     = active_width();
    h     = active_height();
    total = w * h;
    lag   = 2 * w + 2;
    if (in_col >= w) in_col = 0;
    if (it.is_padding) begin
      // flush slot: only does something once the frame is complete
      pout = out_row * w + out_col;
      if (in_row >= h && pout < total) push_result(out_row + 4 - h, 1'b0, w, h);
    end else begin
      if (in_row >= h) restart_frame();
      col = in_col % LINE_MAX;
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) win[r][c] = win[r][c+1];
        if (r < 4) win[r][4] = line_rows[r][col];
        else win[r][4] = it.pixel_in;
      end
      for (int k = 0; k < 3; k++) line_rows[k][col] = line_rows[k+1][col];
      line_rows[3][col] = it.pixel_in;
      pin = in_row * w + in_col;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
      pout = out_row * w + out_col;
      if (pout < total && pin >= pout + lag) push_result(1, 1'b1, w, h);
    end
  endtask

  // watch the channels, predict and compare
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      reset_model();
    end else begin
      if (cfg_we) begin
        if (cfg_reg_t'(cfg_index) == REG_IMAGE_WIDTH) width_reg = cfg_wdata[COL_W-1:0];
        else height_reg = cfg_wdata[ROW_W-1:0];
        restart_frame();
      end
      if (in_valid && !in_stall) blur_step(in_data);
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          report_error($sformatf("result pixel %0d frame_end %0b with nothing expected",
                                 out_data.pixel_out, out_data.frame_end));
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_out !== want.pixel_out)
            report_error($sformatf("pixel_out got %0d expected %0d",
                                   out_data.pixel_out, want.pixel_out));
          if (out_data.frame_end !== want.frame_end)
            report_error($sformatf("frame_end got %0b expected %0b",
                                   out_data.frame_end, want.frame_end));
        end
      end
    end
    pending_count = expected_pixels.size();
  end

endmodule

// File: test/gaussian_blur_5x5_test.sv
module gaussian_blur_5x5_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gb5_pkg::*;

  localparam int LINE_MAX     = 256;
  localparam int SETTLE_CYC   = 16;
  localparam int RANDOM_ITEMS = 1000;
  localparam int RUN_LIMIT_NS = 5_000_000;
  localparam int END_WAIT_CYC = 50_000;

  logic             clk   = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_we;
  logic [0:0]       cfg_index;
  logic [CFG_W-1:0] cfg_wdata;
  int               mismatches;
  int               pending;

  // sizes as the block sees them, tracked to shape the frames
  logic [COL_W-1:0] raw_w       = 9'd256;
  logic [ROW_W-1:0] raw_h       = 12'd256;
  int               cur_w       = 256;
  int               cur_h       = 256;
  int               sent        = 0;
  bit               calm_tx     = 1'b0;
  int               random_done = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gaussian_blur_5x5 #(.MAX_WIDTH(LINE_MAX)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  gaussian_blur_5x5_check #(.LINE_MAX(LINE_MAX)) i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .error_count   (mismatches),
    .pending_count (pending)
  );

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return r[PIX_W-1:0];
    endcase
  endfunction

  // one input transaction; called at a falling edge, returns at a falling edge
  task automatic send_item(input logic pad, input logic [PIX_W-1:0] pix);
    int gap;
    sent++;
    if (sent % 64 == 0) calm_tx = ($urandom_range(0, 3) == 0);
    gap = calm_tx ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.pixel_in <= pix;
    in_data.is_padding <= pad;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // hold off input until every predicted pixel is out, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
  endtask

  // register writes, only with the block idle
  task automatic set_size(input bit do_w, input logic [CFG_W-1:0] w_word,
                          input bit do_h, input logic [CFG_W-1:0] h_word);
    if (do_w) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_IMAGE_WIDTH;
      cfg_wdata <= w_word;
      raw_w = w_word[COL_W-1:0];
      @(negedge clk);
    end
    if (do_h) begin
      cfg_we    <= 1'b1;
      cfg_index <= REG_IMAGE_HEIGHT;
      cfg_wdata <= h_word;
      raw_h = h_word[ROW_W-1:0];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    cur_w = (raw_w == 0) ? 1 : (int'(raw_w) > LINE_MAX) ? LINE_MAX : int'(raw_w);
    cur_h = (raw_h == 0) ? 1 : int'(raw_h);
  endtask

  // pixels of one frame with stray padding inside, then the flush slots
  task automatic feed_frame(input int pixels, input int flush);
    for (int i = 0; i < pixels; i++) begin
      if ($urandom_range(0, 39) == 0) send_item(1'b1, rand_pixel());
      send_item(1'b0, rand_pixel());
      random_done++;
      if ($urandom_range(0, 199) == 0) drain();
    end
    for (int i = 0; i < flush; i++) begin
      send_item(1'b1, rand_pixel());
      random_done++;
    end
  endtask

  // result side: random stall before each result, with calm stretches
  initial begin
    int gap;
    int n_rx;
    bit calm_rx;
    out_stall = 1'b0;
    n_rx      = 0;
    calm_rx   = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      n_rx++;
      if (n_rx % 64 == 0) calm_rx = ($urandom_range(0, 3) == 0);
      gap = calm_rx ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // stimulus and verdict
  initial begin
    int          frames;
    int          total;
    int          flush;
    int          choice;
    int          phase;
    int          n;
    bit          cut;
    logic [2:0]  hb;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // padding in the middle of a frame is ignored
    send_item(1'b1, 8'hFF);

    // width and height of zero act as one; spare padding has nothing to flush
    drain();
    set_size(1'b1, 12'hE00, 1'b1, 12'h000);
    send_item(1'b0, 8'hFF);
    repeat (4) send_item(1'b1, 8'h00);

    // a new frame before the flush is done drops the rest of the old one
    drain();
    set_size(1'b1, 12'd1, 1'b1, 12'd2);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h3C);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'hA5);
    repeat (2) send_item(1'b1, 8'hC3);

    // oversize width clamps, tallest height; the next write restarts the frame
    drain();
    set_size(1'b1, 12'd300, 1'b1, 12'd4095);
    repeat (3) send_item(1'b0, rand_pixel());

    // random phases, each starting with a reconfiguration
    phase = 0;
    while (random_done < RANDOM_ITEMS) begin
      drain();
      choice = $urandom_range(0, 11);
      hb     = 3'($urandom_range(0, 7));
      frames = $urandom_range(1, 3);
      if (phase == 2 || choice == 0) begin
        // full or nearly full width, very few rows
        set_size(1'b1, {hb, (phase == 2) ? 9'd256 : 9'($urandom_range(200, 256))},
                 1'b1, 12'($urandom_range(1, 2)));
        frames = 1;
      end else if (choice == 1) begin
        set_size(1'b1, {hb, 9'd0}, 1'b1, 12'd0);
      end else if (choice == 2) begin
        // clamped width, tall frame cut short
        set_size(1'b1, {hb, 9'($urandom_range(257, 511))}, 1'b1, 12'd4095);
        frames = 0;
        feed_frame($urandom_range(10, 40), 0);
      end else begin
        case ((cur_w <= 12 && cur_h <= 10) ? $urandom_range(0, 3) : 3)
          0:       set_size(1'b1, {hb, 9'($urandom_range(1, 12))}, 1'b0, '0);
          1:       set_size(1'b0, '0, 1'b1, 12'($urandom_range(1, 10)));
          default: set_size(1'b1, {hb, 9'($urandom_range(1, 12))},
                            1'b1, 12'($urandom_range(1, 10)));
        endcase
      end
      for (int f = 0; f < frames; f++) begin
        total = cur_w * cur_h;
        cut   = (f == frames - 1) && ($urandom_range(0, 9) == 0);
        if (cut) begin
          feed_frame($urandom_range(0, total - 1), 0);
        end else begin
          case ($urandom_range(0, 5))
            0:       flush = $urandom_range(0, 2 * cur_w + 1);
            1:       flush = 2 * cur_w + 2 + $urandom_range(1, 5);
            default: flush = 2 * cur_w + 2;
          endcase
          feed_frame(total, flush);
        end
      end
      phase++;
    end

    // wait out the last results
    in_valid <= 1'b0;
    for (n = 0; n < END_WAIT_CYC && pending != 0; n++) @(negedge clk);
    repeat (SETTLE_CYC) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // hard stop
  initial begin
    #(RUN_LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

endmodule
